// ===== rtl/cab_pkg.sv =====
// shared types, constants and lookup tables for the cylindrical array beam level block
`timescale 1ns / 1ps
`default_nettype none
package cab_pkg;

    localparam int MAX_RING     = 64;
    localparam int MAX_STACK    = 64;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 64;

    // cordic start vector, prescaled by the inverse gain, Q30
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [32:0] EL_NEAR_ZERO = 33'd65536;
    localparam logic [10:0] KAZ_SCALE   = 11'd1000;
    localparam logic [10:0] KEL_SCALE   = 11'd2000;
    localparam logic [16:0] LEVEL_MAX   = 17'd65536;

    // register indexes
    localparam logic [2:0] REG_RADIUS  = 3'd0;
    localparam logic [2:0] REG_SPACING = 3'd1;
    localparam logic [2:0] REG_SPEED   = 3'd2;
    localparam logic [2:0] REG_BAFFLE  = 3'd3;
    localparam logic [2:0] REG_RING    = 3'd4;
    localparam logic [2:0] REG_STACK   = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_KAZ_M, ST_KAZ_D, ST_KAZ_W,
        ST_KEL_M, ST_KEL_D, ST_KEL_W,
        ST_STEP_D, ST_STEP_W,
        ST_A_CORD, ST_A_WAIT,
        ST_PD_M1, ST_PD_M2, ST_PD_SUM,
        ST_PH_M1, ST_PH_M2, ST_PH_SUM,
        ST_P_CORD, ST_P_WAIT,
        ST_DIV_RE, ST_W_RE, ST_DIV_IM, ST_W_IM,
        ST_AZ_M1, ST_AZ_M2, ST_AZ_SUM,
        ST_KD_M1, ST_KD_M2, ST_KD_SUM,
        ST_NKD_M, ST_KD_CORD, ST_KD_WAIT,
        ST_DEN_M, ST_N_CORD, ST_N_WAIT, ST_EL_W,
        ST_EL2_M, ST_LV_M, ST_OUT, ST_DONE
    } cab_state_t;

    // arctangent of 2^-i as a fraction of a turn, 2^32 per turn
    function automatic logic [29:0] cab_atan(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cylindrical_array_beam_level.sv =====
// beam power level of a cylindrical array: sequencer around a shared cordic, multiplier and divider
//
//  channel | dir | handshake              | payload
//  s_      | in  | s_tvalid / s_tready    | s_tdata: freq, arrival and steering cosines
//  m_      | out | m_tvalid / m_tready    | m_tdata: power level
//  apb     | in  | psel, penable, pready  | paddr, pwdata, prdata
//
// a request runs two 30-step cordic rotations per ring element, one or two more for the
// stack, and up to six 64-step divisions; a baffled arrival goes straight out as level 0
// s_tready is high only while the sequencer is idle; a finished level waits in
// the output register, and the next request is taken while it waits
// aresetn is synchronous, active low, and restores the register reset values
`timescale 1ns / 1ps
`default_nettype none
module cylindrical_array_beam_level (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // freq_hz[19:0], arr_front[35:20], arr_right[51:36], arr_up[67:52],
    // steer_front[83:68], steer_right[99:84], steer_up[115:100], zero fill
    input  wire logic [119:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // power_level[16:0], zero fill
    output logic [23:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // configuration
    logic [15:0] radius_reg, spacing_reg;
    logic [10:0] speed_reg;
    logic        baffle_reg;
    logic [6:0]  ring_reg, stack_reg;

    logic        cfg_wr;
    logic [10:0] c_eff;
    logic [6:0]  nr, ns;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= 16'd1000;
            spacing_reg <= 16'd500;
            speed_reg   <= 11'd1500;
            baffle_reg  <= 1'b0;
            ring_reg    <= 7'd16;
            stack_reg   <= 7'd8;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                cab_pkg::REG_RADIUS:  radius_reg  <= pwdata[15:0];
                cab_pkg::REG_SPACING: spacing_reg <= pwdata[15:0];
                cab_pkg::REG_SPEED:   speed_reg   <= pwdata[10:0];
                cab_pkg::REG_BAFFLE:  baffle_reg  <= pwdata[0];
                cab_pkg::REG_RING:    ring_reg    <= pwdata[6:0];
                cab_pkg::REG_STACK:   stack_reg   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            cab_pkg::REG_RADIUS:  prdata = {16'b0, radius_reg};
            cab_pkg::REG_SPACING: prdata = {16'b0, spacing_reg};
            cab_pkg::REG_SPEED:   prdata = {21'b0, speed_reg};
            cab_pkg::REG_BAFFLE:  prdata = {31'b0, baffle_reg};
            cab_pkg::REG_RING:    prdata = {25'b0, ring_reg};
            cab_pkg::REG_STACK:   prdata = {25'b0, stack_reg};
            default:              prdata = 32'b0;
        endcase
    end

    assign c_eff = (speed_reg == 11'd0) ? 11'd1 : speed_reg;
    assign nr = (ring_reg == 7'd0) ? 7'd1 :
                (ring_reg > 7'(cab_pkg::MAX_RING)) ? 7'(cab_pkg::MAX_RING) : ring_reg;
    assign ns = (stack_reg == 7'd0) ? 7'd1 :
                (stack_reg > 7'(cab_pkg::MAX_STACK)) ? 7'(cab_pkg::MAX_STACK) : stack_reg;

    // sequencer
    cab_pkg::cab_state_t state_reg, state_next;

    logic        cord_start, div_start;
    logic [31:0] cord_angle;
    logic [63:0] div_dvd_in;
    logic [39:0] div_dvs_in;
    logic        cord_busy_reg, div_busy_reg;
    logic        out_load;
    logic        s_fire;
    logic        m_tvalid_reg;
    logic [16:0] out_reg, res_reg;

    // item and working registers
    logic [19:0]        freq_reg;
    logic signed [16:0] df_reg, dr_reg, du_reg;
    logic [63:0]        kaz_reg, kel_reg;
    logic [31:0]        step_q_reg;
    logic [6:0]         step_r_reg, frac_reg, m_reg;
    logic [31:0]        alpha_reg, ph_reg, kd_reg, nkd_reg;
    logic signed [65:0] prod_reg, t1_reg;
    logic signed [32:0] pd_reg, rem_reg, imm_reg, sa_reg;
    logic signed [37:0] re_reg, im_reg;
    logic [30:0]        az2_reg;
    logic signed [38:0] den_reg;
    logic signed [31:0] el_reg;
    logic               el_neg_reg;

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;

    // cordic
    logic signed [32:0] cx_reg, cy_reg, cz_reg;
    logic [4:0]         ci_reg;
    logic [1:0]         cq_reg;
    logic signed [32:0] cord_cos, cord_sin;
    logic signed [32:0] cdx, cdy, catan;

    // divider
    logic [63:0] div_dvd_reg, div_q_reg;
    logic [39:0] div_dvs_reg, div_r_reg;
    logic [5:0]  div_cnt_reg;
    logic [40:0] div_trial, div_diff;
    logic        div_ge;

    // combinational helpers
    logic signed [65:0] sum66;
    logic [47:0]        ph_low;
    logic [38:0]        kd_low;
    logic [7:0]         frac_sum;
    logic               frac_wrap;
    logic [37:0]        re_abs, im_abs;
    logic [32:0]        sin_abs, rem_q, el_mag_q;
    logic [38:0]        den_abs;
    logic [35:0]        az_sh;
    logic [30:0]        level_rnd;
    logic [16:0]        q16;
    logic               af_nonpos;

    assign s_tready = (state_reg == cab_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_reg};
    assign af_nonpos = s_tdata[35] || (s_tdata[35:20] == 16'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cab_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cord_start = 1'b0;
        cord_angle = 32'b0;
        div_start  = 1'b0;
        div_dvd_in = 64'b0;
        div_dvs_in = 40'b0;
        out_load   = 1'b0;
        mul_a      = 33'sd0;
        mul_b      = 33'sd0;
        unique case (state_reg)
            cab_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = (baffle_reg && af_nonpos) ? cab_pkg::ST_DONE
                                                           : cab_pkg::ST_KAZ_M;
                end
            end
            cab_pkg::ST_KAZ_M: begin
                mul_a = $signed({13'b0, freq_reg});
                mul_b = $signed({17'b0, radius_reg});
                state_next = cab_pkg::ST_KAZ_D;
            end
            cab_pkg::ST_KAZ_D: begin
                div_start  = 1'b1;
                div_dvd_in = 64'({prod_reg[35:0], 24'b0});
                div_dvs_in = 40'(c_eff) * 40'(cab_pkg::KAZ_SCALE);
                state_next = cab_pkg::ST_KAZ_W;
            end
            cab_pkg::ST_KAZ_W: begin
                if (!div_busy_reg) state_next = cab_pkg::ST_KEL_M;
            end
            cab_pkg::ST_KEL_M: begin
                mul_a = $signed({13'b0, freq_reg});
                mul_b = $signed({17'b0, spacing_reg});
                state_next = cab_pkg::ST_KEL_D;
            end
            cab_pkg::ST_KEL_D: begin
                div_start  = 1'b1;
                div_dvd_in = 64'({prod_reg[35:0], 24'b0});
                div_dvs_in = 40'(c_eff) * 40'(cab_pkg::KEL_SCALE);
                state_next = cab_pkg::ST_KEL_W;
            end
            cab_pkg::ST_KEL_W: begin
                if (!div_busy_reg) state_next = cab_pkg::ST_STEP_D;
            end
            cab_pkg::ST_STEP_D: begin
                // one element step of the ring angle, quotient and remainder of a turn
                div_start  = 1'b1;
                div_dvd_in = 64'h1_0000_0000;
                div_dvs_in = 40'(nr);
                state_next = cab_pkg::ST_STEP_W;
            end
            cab_pkg::ST_STEP_W: begin
                if (!div_busy_reg) state_next = cab_pkg::ST_A_CORD;
            end
            cab_pkg::ST_A_CORD: begin
                cord_start = 1'b1;
                cord_angle = alpha_reg;
                state_next = cab_pkg::ST_A_WAIT;
            end
            cab_pkg::ST_A_WAIT: begin
                if (!cord_busy_reg) state_next = cab_pkg::ST_PD_M1;
            end
            cab_pkg::ST_PD_M1: begin
                mul_a = 33'(df_reg);
                mul_b = cord_cos;
                state_next = cab_pkg::ST_PD_M2;
            end
            cab_pkg::ST_PD_M2: begin
                mul_a = 33'(dr_reg);
                mul_b = cord_sin;
                state_next = cab_pkg::ST_PD_SUM;
            end
            cab_pkg::ST_PD_SUM: state_next = cab_pkg::ST_PH_M1;
            cab_pkg::ST_PH_M1: begin
                mul_a = $signed({9'b0, kaz_reg[23:0]});
                mul_b = pd_reg;
                state_next = cab_pkg::ST_PH_M2;
            end
            cab_pkg::ST_PH_M2: begin
                mul_a = $signed({9'b0, kaz_reg[47:24]});
                mul_b = pd_reg;
                state_next = cab_pkg::ST_PH_SUM;
            end
            cab_pkg::ST_PH_SUM: state_next = cab_pkg::ST_P_CORD;
            cab_pkg::ST_P_CORD: begin
                cord_start = 1'b1;
                cord_angle = ph_reg;
                state_next = cab_pkg::ST_P_WAIT;
            end
            cab_pkg::ST_P_WAIT: begin
                if (!cord_busy_reg) begin
                    state_next = (m_reg + 7'd1 == nr) ? cab_pkg::ST_DIV_RE
                                                      : cab_pkg::ST_A_CORD;
                end
            end
            cab_pkg::ST_DIV_RE: begin
                div_start  = 1'b1;
                div_dvd_in = 64'(re_abs);
                div_dvs_in = 40'(nr);
                state_next = cab_pkg::ST_W_RE;
            end
            cab_pkg::ST_W_RE: begin
                if (!div_busy_reg) state_next = cab_pkg::ST_DIV_IM;
            end
            cab_pkg::ST_DIV_IM: begin
                div_start  = 1'b1;
                div_dvd_in = 64'(im_abs);
                div_dvs_in = 40'(nr);
                state_next = cab_pkg::ST_W_IM;
            end
            cab_pkg::ST_W_IM: begin
                if (!div_busy_reg) state_next = cab_pkg::ST_AZ_M1;
            end
            cab_pkg::ST_AZ_M1: begin
                mul_a = rem_reg;
                mul_b = rem_reg;
                state_next = cab_pkg::ST_AZ_M2;
            end
            cab_pkg::ST_AZ_M2: begin
                mul_a = imm_reg;
                mul_b = imm_reg;
                state_next = cab_pkg::ST_AZ_SUM;
            end
            cab_pkg::ST_AZ_SUM: state_next = cab_pkg::ST_KD_M1;
            cab_pkg::ST_KD_M1: begin
                mul_a = $signed({9'b0, kel_reg[23:0]});
                mul_b = 33'(du_reg);
                state_next = cab_pkg::ST_KD_M2;
            end
            cab_pkg::ST_KD_M2: begin
                mul_a = $signed({18'b0, kel_reg[38:24]});
                mul_b = 33'(du_reg);
                state_next = cab_pkg::ST_KD_SUM;
            end
            cab_pkg::ST_KD_SUM: state_next = cab_pkg::ST_NKD_M;
            cab_pkg::ST_NKD_M: begin
                mul_a = $signed({1'b0, kd_reg});
                mul_b = $signed({26'b0, ns});
                state_next = cab_pkg::ST_KD_CORD;
            end
            cab_pkg::ST_KD_CORD: begin
                cord_start = 1'b1;
                cord_angle = kd_reg;
                state_next = cab_pkg::ST_KD_WAIT;
            end
            cab_pkg::ST_KD_WAIT: begin
                if (!cord_busy_reg) begin
                    state_next = (sin_abs < cab_pkg::EL_NEAR_ZERO) ? cab_pkg::ST_EL2_M
                                                                   : cab_pkg::ST_DEN_M;
                end
            end
            cab_pkg::ST_DEN_M: begin
                mul_a = sa_reg;
                mul_b = $signed({26'b0, ns});
                state_next = cab_pkg::ST_N_CORD;
            end
            cab_pkg::ST_N_CORD: begin
                cord_start = 1'b1;
                cord_angle = nkd_reg;
                state_next = cab_pkg::ST_N_WAIT;
            end
            cab_pkg::ST_N_WAIT: begin
                if (!cord_busy_reg) begin
                    div_start  = 1'b1;
                    div_dvd_in = 64'(sin_abs) << 30;
                    div_dvs_in = 40'(den_abs);
                    state_next = cab_pkg::ST_EL_W;
                end
            end
            cab_pkg::ST_EL_W: begin
                if (!div_busy_reg) state_next = cab_pkg::ST_EL2_M;
            end
            cab_pkg::ST_EL2_M: begin
                mul_a = 33'(el_reg);
                mul_b = 33'(el_reg);
                state_next = cab_pkg::ST_LV_M;
            end
            cab_pkg::ST_LV_M: begin
                mul_a = $signed({2'b0, az2_reg});
                mul_b = $signed({1'b0, prod_reg[61:30]});
                state_next = cab_pkg::ST_OUT;
            end
            cab_pkg::ST_OUT: state_next = cab_pkg::ST_DONE;
            cab_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = cab_pkg::ST_IDLE;
                end
            end
            default: state_next = cab_pkg::ST_IDLE;
        endcase
    end

    // datapath helpers
    assign sum66     = t1_reg + prod_reg;
    assign ph_low    = t1_reg[47:0] + {prod_reg[23:0], 24'b0};
    assign kd_low    = t1_reg[38:0] + {prod_reg[14:0], 24'b0};
    assign frac_sum  = {1'b0, frac_reg} + {1'b0, step_r_reg};
    assign frac_wrap = (frac_sum >= {1'b0, nr});
    assign re_abs    = re_reg[37] ? 38'(-re_reg) : 38'(re_reg);
    assign im_abs    = im_reg[37] ? 38'(-im_reg) : 38'(im_reg);
    assign sin_abs   = cord_sin[32] ? 33'(-cord_sin) : 33'(cord_sin);
    assign den_abs   = den_reg[38] ? 39'(-den_reg) : 39'(den_reg);
    assign rem_q     = div_q_reg[32:0];
    assign el_mag_q  = (div_q_reg > 64'(cab_pkg::Q30_ONE)) ? 33'(cab_pkg::Q30_ONE)
                                                          : div_q_reg[32:0];
    assign az_sh     = sum66[65:30];
    assign level_rnd = prod_reg[60:30] + 31'd8192;
    assign q16       = (level_rnd[30:14] > cab_pkg::LEVEL_MAX) ? cab_pkg::LEVEL_MAX
                                                                : level_rnd[30:14];

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            cab_pkg::ST_IDLE: begin
                if (s_fire) begin
                    freq_reg <= s_tdata[19:0];
                    df_reg   <= 17'($signed(s_tdata[35:20])) - 17'($signed(s_tdata[83:68]));
                    dr_reg   <= 17'($signed(s_tdata[51:36])) - 17'($signed(s_tdata[99:84]));
                    du_reg   <= 17'($signed(s_tdata[67:52])) - 17'($signed(s_tdata[115:100]));
                    res_reg  <= 17'd0;
                end
            end
            cab_pkg::ST_KAZ_W: kaz_reg <= div_q_reg;
            cab_pkg::ST_KEL_W: kel_reg <= div_q_reg;
            cab_pkg::ST_STEP_W: begin
                step_q_reg <= div_q_reg[31:0];
                step_r_reg <= div_r_reg[6:0];
                alpha_reg  <= 32'd0;
                frac_reg   <= 7'd0;
                m_reg      <= 7'd0;
                re_reg     <= 38'sd0;
                im_reg     <= 38'sd0;
            end
            cab_pkg::ST_PD_M2:  t1_reg <= prod_reg;
            cab_pkg::ST_PD_SUM: pd_reg <= 33'(sum66 >>> 21);
            cab_pkg::ST_PH_M2:  t1_reg <= prod_reg;
            cab_pkg::ST_PH_SUM: ph_reg <= ph_low[47:16];
            cab_pkg::ST_P_WAIT: begin
                if (!cord_busy_reg) begin
                    re_reg <= re_reg + 38'(cord_cos);
                    im_reg <= im_reg - 38'(cord_sin);
                    m_reg  <= m_reg + 7'd1;
                    // running floor(m * turn / nr)
                    alpha_reg <= alpha_reg + step_q_reg + 32'(frac_wrap);
                    frac_reg  <= frac_wrap ? 7'(frac_sum - {1'b0, nr}) : frac_sum[6:0];
                end
            end
            cab_pkg::ST_W_RE: begin
                if (!div_busy_reg) rem_reg <= re_reg[37] ? -$signed(rem_q) : $signed(rem_q);
            end
            cab_pkg::ST_W_IM: begin
                if (!div_busy_reg) imm_reg <= im_reg[37] ? -$signed(rem_q) : $signed(rem_q);
            end
            cab_pkg::ST_AZ_M2: t1_reg <= prod_reg;
            cab_pkg::ST_AZ_SUM: begin
                az2_reg <= (az_sh > 36'(cab_pkg::Q30_ONE)) ? cab_pkg::Q30_ONE : az_sh[30:0];
            end
            cab_pkg::ST_KD_M2:   t1_reg <= prod_reg;
            cab_pkg::ST_KD_SUM:  kd_reg <= kd_low[38:7];
            cab_pkg::ST_KD_CORD: nkd_reg <= prod_reg[31:0];
            cab_pkg::ST_KD_WAIT: begin
                if (!cord_busy_reg) begin
                    sa_reg <= cord_sin;
                    el_reg <= 32'($signed({1'b0, cab_pkg::Q30_ONE}));
                end
            end
            cab_pkg::ST_N_CORD: den_reg <= prod_reg[38:0];
            cab_pkg::ST_N_WAIT: begin
                if (!cord_busy_reg) el_neg_reg <= cord_sin[32] ^ den_reg[38];
            end
            cab_pkg::ST_EL_W: begin
                if (!div_busy_reg) begin
                    el_reg <= el_neg_reg ? 32'(-$signed(el_mag_q)) : 32'($signed(el_mag_q));
                end
            end
            cab_pkg::ST_OUT: res_reg <= q16;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) out_reg <= res_reg;
    end

    // cordic, one micro-rotation a cycle
    assign cdx   = cy_reg >>> ci_reg;
    assign cdy   = cx_reg >>> ci_reg;
    assign catan = $signed({3'b0, cab_pkg::cab_atan(ci_reg)});

    always_comb begin
        case (cq_reg)
            2'd0: begin
                cord_cos = cx_reg;
                cord_sin = cy_reg;
            end
            2'd1: begin
                cord_cos = -cy_reg;
                cord_sin = cx_reg;
            end
            2'd2: begin
                cord_cos = -cx_reg;
                cord_sin = -cy_reg;
            end
            default: begin
                cord_cos = cy_reg;
                cord_sin = -cx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cord_busy_reg <= 1'b0;
        end else if (cord_start) begin
            cx_reg        <= cab_pkg::CORDIC_X0;
            cy_reg        <= 33'sd0;
            cz_reg        <= $signed({3'b0, cord_angle[29:0]});
            cq_reg        <= cord_angle[31:30];
            ci_reg        <= 5'd0;
            cord_busy_reg <= 1'b1;
        end else if (cord_busy_reg) begin
            if (!cz_reg[32]) begin
                cx_reg <= cx_reg - cdx;
                cy_reg <= cy_reg + cdy;
                cz_reg <= cz_reg - catan;
            end else begin
                cx_reg <= cx_reg + cdx;
                cy_reg <= cy_reg - cdy;
                cz_reg <= cz_reg + catan;
            end
            ci_reg <= ci_reg + 5'd1;
            if (ci_reg == 5'(cab_pkg::CORDIC_STEPS - 1)) cord_busy_reg <= 1'b0;
        end
    end

    // restoring divider, one quotient bit a cycle
    assign div_trial = {div_r_reg, div_dvd_reg[63]};
    assign div_ge    = (div_trial >= {1'b0, div_dvs_reg});
    assign div_diff  = div_trial - {1'b0, div_dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
        end else if (div_start) begin
            div_dvd_reg  <= div_dvd_in;
            div_dvs_reg  <= div_dvs_in;
            div_r_reg    <= 40'd0;
            div_q_reg    <= 64'd0;
            div_cnt_reg  <= 6'd0;
            div_busy_reg <= 1'b1;
        end else if (div_busy_reg) begin
            div_r_reg   <= div_ge ? div_diff[39:0] : div_trial[39:0];
            div_q_reg   <= {div_q_reg[62:0], div_ge};
            div_dvd_reg <= {div_dvd_reg[62:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + 6'd1;
            if (div_cnt_reg == 6'(cab_pkg::DIV_STEPS - 1)) div_busy_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire
